### src/tpgms_pkg.sv
// ----------------------------------------------------------------------------
// tpgms_pkg
// Shared types and constants of the two-path grid maximum sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package tpgms_pkg;

    // default largest grid side
    localparam int MAX_N_DEF = 16;

    // field widths
    localparam int VAL_W  = 16;
    localparam int SUM_W  = 22;
    localparam int CFG_W  = 5;
    localparam int ROW_W  = 5;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register map: paddr[2] selects the register
    localparam logic             REG_GRID_SIZE = 1'b0;
    localparam logic [CFG_W-1:0] GRID_SIZE_RST = 5'd9;

    // command codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_SOLVE = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_COMP,
        ST_DRAIN,
        ST_FIN
    } t_state;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic ld;     // shift diagonal values down the chain
        logic cp;     // compute one layer entry and rotate the row
        logic first;  // first diagonal: previous layer reads as zero
        logic k0;     // column index zero: k-1 neighbors read as zero
        logic kok;    // second path's cell is inside the grid
    } t_cell_ctl;

endpackage

`default_nettype wire

### src/tpgms_ram.sv
// ----------------------------------------------------------------------------
// tpgms_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tpgms_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/tpgms_cell.sv
// ----------------------------------------------------------------------------
// tpgms_cell
// One cell of the layer chain. Cell IDX owns the row of the DP layer where the
// first path stands in row IDX. The row rotates through a shift line, one
// entry per compute cycle, while the cell hands its head entry and the entry
// before it to the next cell down the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module tpgms_cell
    import tpgms_pkg::*;
#(
    parameter  int MAX_N = MAX_N_DEF,
    parameter  int IDX   = 0,
    localparam int IW    = (MAX_N > 1) ? $clog2(MAX_N) : 1
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [IW-1:0]    i_k,
    input  logic [VAL_W-1:0] i_gk,
    input  logic [VAL_W-1:0] i_g,
    input  logic             i_gok,
    input  logic [SUM_W-1:0] i_up_head,
    input  logic [SUM_W-1:0] i_up_prv,
    output logic [VAL_W-1:0] o_g,
    output logic             o_gok,
    output logic [SUM_W-1:0] o_head,
    output logic [SUM_W-1:0] o_prv,
    output logic [SUM_W-1:0] o_cur
);

    logic [SUM_W-1:0] r_line [MAX_N];
    logic [SUM_W-1:0] r_prv;
    logic [VAL_W-1:0] r_g;
    logic             r_gok;

    logic [SUM_W-1:0] own_k, own_km1, up_k, up_km1;
    logic [SUM_W-1:0] max_own, max_up, best, sum;
    logic [VAL_W-1:0] add_k;

    // best of the four predecessor entries, then add the two cells
    always_comb begin
        own_k   = i_ctl.first ? '0 : r_line[0];
        own_km1 = (i_ctl.first || i_ctl.k0) ? '0 : r_prv;
        up_k    = i_ctl.first ? '0 : i_up_head;
        up_km1  = (i_ctl.first || i_ctl.k0) ? '0 : i_up_prv;
        max_own = (own_k > own_km1) ? own_k : own_km1;
        max_up  = (up_k > up_km1) ? up_k : up_km1;
        best    = (max_own > max_up) ? max_own : max_up;
        // shared cell counts once
        add_k   = (i_k == IW'(IDX)) ? '0 : i_gk;
        sum     = best + SUM_W'(r_g) + SUM_W'(add_k);
        o_cur   = (r_gok && i_ctl.kok) ? sum : '0;
    end

    // diagonal value shift and row rotation
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld) begin
            r_g   <= i_g;
            r_gok <= i_gok;
        end
        if (i_ctl.cp) begin
            for (int j = 0; j < MAX_N - 1; j++) begin
                r_line[j] <= r_line[j+1];
            end
            r_line[MAX_N-1] <= o_cur;
            r_prv           <= r_line[0];
        end
    end

    assign o_g    = r_g;
    assign o_gok  = r_gok;
    assign o_head = r_line[0];
    assign o_prv  = r_prv;

endmodule

`default_nettype wire

### src/two_path_grid_max_sum.sv
// ----------------------------------------------------------------------------
// two_path_grid_max_sum
// Loads a square grid of cell values and finds the largest total that two
// down/right paths from corner to corner can collect, shared cells once.
// ----------------------------------------------------------------------------
// A write word (func 0) stores one cell; writes outside the grid
// size in use are dropped. A solve word (func 1) runs the anti-diagonal DP on
// a chain of MAX_N cells, one cell per row of the first path: for each of
// the 2n-1 diagonals of grid side n it loads the diagonal's cell values
// down the chain, then rotates every cell's layer row once through the
// update. The result is then loaded into the output register and the grid
// RAM is cleared, one entry a cycle, over all MAX_N*MAX_N entries; the same
// clearing pass runs after reset. No word is taken during a solve or a
// clearing pass; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module two_path_grid_max_sum
    import tpgms_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input words
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_func,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [ROW_W-1:0]  i_col,
    input  logic [VAL_W-1:0]  i_cell_value,
    // result words
    output logic              o_valid,
    input  logic              i_ready,
    output logic [SUM_W-1:0]  o_best_sum,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int DEPTH = MAX_N * MAX_N;
    localparam int IW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (MAX_N > 1) ? $clog2(2 * MAX_N - 1) : 1;
    localparam int DW    = SW + 1;
    localparam int GW    = (DW > CFG_W) ? DW : CFG_W;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_grid_size;
    logic [IW-1:0]    r_k, n_k;
    logic [SW-1:0]    r_s, n_s;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic             r_out_vld, n_out_vld;
    logic [SUM_W-1:0] r_out_sum;
    logic [SUM_W-1:0] r_ans;

    // read pipeline tags, registered alongside the RAM read data
    logic             r_q_ld, r_q_cp;
    logic [IW-1:0]    r_q_k;
    logic             r_q_ok, r_q_first, r_q_last;

    logic [GW-1:0]    gs_x, row_x, col_x;
    logic [DW-1:0]    n_use, last_s, k_x, s_x, d_x;
    logic             wr_ok, rd_ok, in_acc, out_free, cfg_wr;
    logic [IW-1:0]    wr_row, wr_col;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata, ram_rdata, g_bus;
    logic             iss_ld, iss_cp;
    t_cell_ctl        cell_ctl;

    logic [VAL_W-1:0] g_in   [MAX_N];
    logic             gok_in [MAX_N];
    logic [SUM_W-1:0] up_head [MAX_N];
    logic [SUM_W-1:0] up_prv  [MAX_N];
    logic [VAL_W-1:0] g_out   [MAX_N];
    logic             gok_out [MAX_N];
    logic [SUM_W-1:0] head_bus [MAX_N];
    logic [SUM_W-1:0] prv_bus  [MAX_N];
    logic [SUM_W-1:0] cur_bus  [MAX_N];

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_GRID_SIZE) ? APB_DW'(r_grid_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_SIZE_RST;
        end else if (cfg_wr && paddr[2] == REG_GRID_SIZE) begin
            r_grid_size <= pwdata[CFG_W-1:0];
        end
    end

    // grid side in use, clamped to 1..MAX_N
    always_comb begin
        gs_x = GW'(r_grid_size);
        if (gs_x == '0) begin
            n_use = DW'(1);
        end else if (gs_x > GW'(MAX_N)) begin
            n_use = DW'(MAX_N);
        end else begin
            n_use = DW'(gs_x);
        end
        last_s = DW'({n_use, 1'b0} - (DW + 1)'(2));
    end

    // cell write address and range check
    always_comb begin
        row_x   = GW'(i_row);
        col_x   = GW'(i_col);
        wr_ok   = (row_x != '0) && (row_x <= GW'(n_use)) &&
                  (col_x != '0) && (col_x <= GW'(n_use));
        wr_row  = IW'(row_x - GW'(1));
        wr_col  = IW'(col_x - GW'(1));
        wr_addr = AW'(wr_row) * AW'(MAX_N) + AW'(wr_col);
    end

    // diagonal read address: row k, column s-k
    always_comb begin
        k_x     = DW'(r_k);
        s_x     = DW'(r_s);
        d_x     = s_x - k_x;
        rd_ok   = (k_x < n_use) && (k_x <= s_x) && (d_x < n_use);
        rd_addr = rd_ok ? (AW'(r_k) * AW'(MAX_N) + AW'(d_x)) : '0;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc && i_func == FUNC_SOLVE) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (r_k == '0) n_state = ST_COMP;
            end
            ST_COMP: begin
                if (r_k == IW'(MAX_N - 1)) begin
                    n_state = (s_x == last_s) ? ST_DRAIN : ST_LOAD;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) n_state = ST_CLEAR;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_ready   = (r_state == ST_IDLE);
        in_acc    = i_valid && o_ready;
        out_free  = !r_out_vld || i_ready;
        iss_ld    = (r_state == ST_LOAD);
        iss_cp    = (r_state == ST_COMP);
        ram_we    = (r_state == ST_CLEAR) || (in_acc && i_func == FUNC_WRITE && wr_ok);
        ram_waddr = (r_state == ST_CLEAR) ? r_clr_addr : wr_addr;
        ram_wdata = (r_state == ST_CLEAR) ? '0 : i_cell_value;
    end

    // counters and output register next values
    always_comb begin
        n_k        = r_k;
        n_s        = r_s;
        n_clr_addr = r_clr_addr;
        n_out_vld  = r_out_vld && !i_ready;
        case (r_state)
            ST_CLEAR: n_clr_addr = r_clr_addr + AW'(1);
            ST_IDLE: begin
                n_s = '0;
                n_k = IW'(MAX_N - 1);
            end
            ST_LOAD: begin
                if (r_k != '0) n_k = r_k - IW'(1);
            end
            ST_COMP: begin
                if (r_k == IW'(MAX_N - 1)) begin
                    n_s = r_s + SW'(1);
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_clr_addr = '0;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_k        <= '0;
            r_s        <= '0;
            r_clr_addr <= '0;
            r_out_vld  <= 1'b0;
            r_q_ld     <= 1'b0;
            r_q_cp     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_k        <= n_k;
            r_s        <= n_s;
            r_clr_addr <= n_clr_addr;
            r_out_vld  <= n_out_vld;
            r_q_ld     <= iss_ld;
            r_q_cp     <= iss_cp;
        end
    end

    // read tags, answer capture and result payload
    always_ff @(posedge i_clk) begin
        r_q_k     <= r_k;
        r_q_ok    <= rd_ok;
        r_q_first <= (r_s == '0);
        r_q_last  <= (s_x == last_s);
        if (r_q_cp && r_q_last && DW'(r_q_k) == n_use - DW'(1)) begin
            r_ans <= cur_bus[IW'(n_use - DW'(1))];
        end
        if (r_state == ST_FIN && out_free) begin
            r_out_sum <= r_ans;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_best_sum = r_out_sum;

    // grid store
    tpgms_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // cells outside the grid read as zero
    assign g_bus = r_q_ok ? ram_rdata : '0;

    assign cell_ctl.ld    = r_q_ld;
    assign cell_ctl.cp    = r_q_cp;
    assign cell_ctl.first = r_q_first;
    assign cell_ctl.k0    = (r_q_k == '0);
    assign cell_ctl.kok   = r_q_ok;

    // chain of cells, one per row of the first path
    for (genvar gi = 0; gi < MAX_N; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            assign g_in[gi]    = g_bus;
            assign gok_in[gi]  = r_q_ok;
            assign up_head[gi] = '0;
            assign up_prv[gi]  = '0;
        end else begin : g_link
            assign g_in[gi]    = g_out[gi-1];
            assign gok_in[gi]  = gok_out[gi-1];
            assign up_head[gi] = head_bus[gi-1];
            assign up_prv[gi]  = prv_bus[gi-1];
        end

        tpgms_cell #(
            .MAX_N (MAX_N),
            .IDX   (gi)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (cell_ctl),
            .i_k       (r_q_k),
            .i_gk      (g_bus),
            .i_g       (g_in[gi]),
            .i_gok     (gok_in[gi]),
            .i_up_head (up_head[gi]),
            .i_up_prv  (up_prv[gi]),
            .o_g       (g_out[gi]),
            .o_gok     (gok_out[gi]),
            .o_head    (head_bus[gi]),
            .o_prv     (prv_bus[gi]),
            .o_cur     (cur_bus[gi])
        );
    end

endmodule

`default_nettype wire

### src/tpgms_chk.sv
// ----------------------------------------------------------------------------
// tpgms_chk
// Port-level checks of the two-path grid maximum sum block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tpgms_chk
    import tpgms_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              i_func,
    input logic [ROW_W-1:0]  i_row,
    input logic [ROW_W-1:0]  i_col,
    input logic [VAL_W-1:0]  i_cell_value,
    input logic              o_valid,
    input logic              i_ready,
    input logic [SUM_W-1:0]  o_best_sum,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [APB_DW-1:0] pwdata,
    input logic [APB_DW-1:0] prdata,
    input logic              pready
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_best_sum))
        else $error("result word dropped or changed while stalled");

    // the grid is cleared after reset before any word is taken
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("input taken right after reset");

    // a solve blocks the input side
    a_solve_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_func == FUNC_SOLVE |=> !o_ready)
        else $error("input taken right after a solve word");

    // a result shows up only at the end of a solve, then the grid is cleared
    a_out_from_solve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !o_ready && $past(!o_ready))
        else $error("result word outside the end of a solve");

endmodule

bind two_path_grid_max_sum tpgms_chk u_chk (.*);

`default_nettype wire
